### rtl/obl_pkg.sv
// ----------------------------------------------------------------------------
// obl_pkg
// Shared constants, types and codes of the order book level tracker.
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int PROBE_COUNT = 4;
  localparam int LEVEL_COUNT = 10;

  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int PRB_W  = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
  localparam int LVL_IW = $clog2(LEVEL_COUNT);

  localparam logic [3:0] MODE_ADD    = 4'd1;
  localparam logic [3:0] MODE_CANCEL = 4'd2;
  localparam logic [3:0] MODE_TRADE  = 4'd3;

  localparam logic REG_PX_BASE = 1'b0;

  typedef struct packed {
    logic        valid;
    logic        side;
    logic [15:0] qty;
    logic [23:0] delta;
    logic [31:0] key;
  } ord_entry_t;

  localparam int ENTRY_W = $bits(ord_entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_UPD,
    ST_WAIT,
    ST_DONE
  } obl_state_t;

  typedef struct packed {
    logic        add_go;
    logic        rm_go;
    logic        side;
    logic [31:0] price;
    logic [31:0] amount;
  } lv_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] bid_px;
    logic [31:0] bid_qty;
    logic [31:0] ask_px;
    logic [31:0] ask_qty;
  } lv_stat_t;

endpackage

### rtl/obl_ram.sv
// ----------------------------------------------------------------------------
// obl_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module obl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/obl_levels.sv
// ----------------------------------------------------------------------------
// obl_levels
// Bid and ask level tables: a direct add and a one-level-per-cycle
// reduction scan that deletes emptied levels.
// ----------------------------------------------------------------------------
module obl_levels (
  input  logic             clk,
  input  logic             rst_n,
  input  obl_pkg::lv_cmd_t cmd_i,
  output obl_pkg::lv_stat_t stat_o
);

  logic [31:0] pr_r   [2][obl_pkg::LEVEL_COUNT];
  logic [31:0] qt_r   [2][obl_pkg::LEVEL_COUNT];
  logic [31:0] pr_nxt [2][obl_pkg::LEVEL_COUNT];
  logic [31:0] qt_nxt [2][obl_pkg::LEVEL_COUNT];

  logic                      scan_act_r,   scan_act_nxt;
  logic [obl_pkg::LVL_IW-1:0] scan_j_r,    scan_j_nxt;
  logic                      scan_side_r,  scan_side_nxt;
  logic [31:0]               scan_price_r, scan_price_nxt;
  logic [31:0]               scan_amt_r,   scan_amt_nxt;

  logic                      eq_hit;
  logic                      empty_hit;
  logic [obl_pkg::LVL_IW-1:0] eq_idx;
  logic [obl_pkg::LVL_IW-1:0] empty_idx;
  logic [obl_pkg::LVL_IW-1:0] sel_idx;
  logic [31:0]               cur_q;
  logic [31:0]               red_q;

  always_comb begin
    pr_nxt         = pr_r;
    qt_nxt         = qt_r;
    scan_act_nxt   = scan_act_r;
    scan_j_nxt     = scan_j_r;
    scan_side_nxt  = scan_side_r;
    scan_price_nxt = scan_price_r;
    scan_amt_nxt   = scan_amt_r;
    eq_hit         = 1'b0;
    empty_hit      = 1'b0;
    eq_idx         = '0;
    empty_idx      = '0;
    sel_idx        = '0;
    cur_q          = qt_r[scan_side_r][scan_j_r];
    red_q          = (cur_q > scan_amt_r) ? (cur_q - scan_amt_r) : 32'd0;

    if (cmd_i.add_go) begin
      for (int j = obl_pkg::LEVEL_COUNT - 1; j >= 0; j--) begin
        if (pr_r[cmd_i.side][j] == cmd_i.price) begin
          eq_hit = 1'b1;
          eq_idx = obl_pkg::LVL_IW'(j);
        end
        if (qt_r[cmd_i.side][j] == 32'd0) begin
          empty_hit = 1'b1;
          empty_idx = obl_pkg::LVL_IW'(j);
        end
      end
      sel_idx = eq_hit ? eq_idx : empty_idx;
      if (eq_hit || empty_hit) begin
        qt_nxt[cmd_i.side][sel_idx] = qt_r[cmd_i.side][sel_idx] + cmd_i.amount;
        pr_nxt[cmd_i.side][sel_idx] = cmd_i.price;
      end
    end

    if (cmd_i.rm_go) begin
      scan_act_nxt   = 1'b1;
      scan_j_nxt     = '0;
      scan_side_nxt  = cmd_i.side;
      scan_price_nxt = cmd_i.price;
      scan_amt_nxt   = cmd_i.amount;
    end else if (scan_act_r) begin
      if (pr_r[scan_side_r][scan_j_r] == scan_price_r) begin
        if (red_q == 32'd0) begin
          for (int k = 0; k < obl_pkg::LEVEL_COUNT - 1; k++) begin
            if (k >= int'(scan_j_r)) begin
              pr_nxt[scan_side_r][k] = pr_r[scan_side_r][k + 1];
              qt_nxt[scan_side_r][k] = qt_r[scan_side_r][k + 1];
            end
          end
          pr_nxt[scan_side_r][obl_pkg::LEVEL_COUNT - 1] = 32'd0;
          qt_nxt[scan_side_r][obl_pkg::LEVEL_COUNT - 1] = 32'd0;
        end else begin
          qt_nxt[scan_side_r][scan_j_r] = red_q;
        end
      end
      if (scan_j_r == obl_pkg::LVL_IW'(obl_pkg::LEVEL_COUNT - 1)) begin
        scan_act_nxt = 1'b0;
      end else begin
        scan_j_nxt = scan_j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        for (int j = 0; j < obl_pkg::LEVEL_COUNT; j++) begin
          pr_r[s][j] <= 32'd0;
          qt_r[s][j] <= 32'd0;
        end
      end
    end else begin
      scan_act_r <= scan_act_nxt;
      pr_r       <= pr_nxt;
      qt_r       <= qt_nxt;
    end
    scan_j_r     <= scan_j_nxt;
    scan_side_r  <= scan_side_nxt;
    scan_price_r <= scan_price_nxt;
    scan_amt_r   <= scan_amt_nxt;
  end

  assign stat_o.busy    = scan_act_r;
  assign stat_o.bid_px  = pr_r[0][0];
  assign stat_o.bid_qty = qt_r[0][0];
  assign stat_o.ask_px  = pr_r[1][0];
  assign stat_o.ask_qty = qt_r[1][0];

endmodule

### rtl/order_book_level_tracker.sv
// ----------------------------------------------------------------------------
// order_book_level_tracker
// Order table in one RAM with linear probing, plus bid and ask level tables.
// ----------------------------------------------------------------------------
// Each probe reads the RAM in ST_READ and compares in ST_CMP, followed by an
// update in ST_UPD and the result registered from ST_DONE; a cancel or trade of a
// found order also waits in ST_WAIT for the level scan. Busy stays high throughout.
// After reset the order RAM is cleared with busy high.
// The result strobe lasts one cycle and cannot be stalled.
module order_book_level_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_mode,
  input  logic [3:0]  in_side,
  input  logic [7:0]  in_instr_id,
  input  logic [31:0] in_timestamp,
  input  logic [31:0] in_price,
  input  logic [15:0] in_quantity,
  input  logic [31:0] in_order_key,
  output logic        out_valid,
  output logic [31:0] out_time_out,
  output logic [31:0] out_exec_px,
  output logic [31:0] out_best_bid_px,
  output logic [31:0] out_best_ask_px,
  output logic [31:0] out_best_bid_qty,
  output logic [31:0] out_best_ask_qty,
  output logic [7:0]  out_security_out,
  output logic [3:0]  out_mode_out,
  output logic [3:0]  out_side_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  obl_pkg::obl_state_t state_r, state_nxt;

  logic [obl_pkg::TBL_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [obl_pkg::PRB_W-1:0]  probe_r,    probe_nxt;
  logic [obl_pkg::TBL_AW-1:0] slot_r,     slot_nxt;
  logic                       found_r,    found_nxt;
  obl_pkg::ord_entry_t        entry_r,    entry_nxt;
  logic [31:0]                offset_r;

  logic [3:0]  mode_r,  mode_nxt;
  logic [3:0]  side_r,  side_nxt;
  logic [7:0]  sec_r,   sec_nxt;
  logic [31:0] ts_r,    ts_nxt;
  logic [31:0] price_r, price_nxt;
  logic [15:0] qty_r,   qty_nxt;
  logic [31:0] key_r,   key_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] o_time_r,  o_time_nxt;
  logic [31:0] o_trade_r, o_trade_nxt;
  logic [31:0] o_bidp_r,  o_bidp_nxt;
  logic [31:0] o_askp_r,  o_askp_nxt;
  logic [31:0] o_bidq_r,  o_bidq_nxt;
  logic [31:0] o_askq_r,  o_askq_nxt;
  logic [7:0]  o_sec_r,   o_sec_nxt;
  logic [3:0]  o_mode_r,  o_mode_nxt;
  logic [3:0]  o_side_r,  o_side_nxt;

  logic                       ram_we;
  logic                       ram_re;
  logic [obl_pkg::TBL_AW-1:0] ram_waddr;
  logic [obl_pkg::TBL_AW-1:0] ram_raddr;
  obl_pkg::ord_entry_t        ram_wdata;
  obl_pkg::ord_entry_t        ram_rdata;

  obl_pkg::lv_cmd_t  lv_cmd;
  obl_pkg::lv_stat_t lv_stat;

  logic        hit;
  logic        last_probe;
  logic        is_rm;
  logic [31:0] actual;
  logic [15:0] amount;
  logic [31:0] add_delta;

  assign ram_raddr  = key_r[obl_pkg::TBL_AW-1:0] + obl_pkg::TBL_AW'(probe_r);
  assign hit        = ram_rdata.valid && (ram_rdata.key == key_r);
  assign last_probe = (probe_r == obl_pkg::PRB_W'(obl_pkg::PROBE_COUNT - 1));
  assign is_rm      = ((mode_r == obl_pkg::MODE_CANCEL) || (mode_r == obl_pkg::MODE_TRADE))
                      && found_r;
  assign actual     = found_r ? (offset_r + {8'd0, entry_r.delta}) : price_r;
  assign amount     = (mode_r == obl_pkg::MODE_CANCEL) ? entry_r.qty : qty_r;
  assign add_delta  = price_r - offset_r;

  obl_ram #(
    .WIDTH(obl_pkg::ENTRY_W),
    .DEPTH(obl_pkg::TABLE_DEPTH)
  ) u_order_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  obl_levels u_levels (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (lv_cmd),
    .stat_o(lv_stat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      obl_pkg::ST_CLEAR: begin
        if (clr_addr_r == {obl_pkg::TBL_AW{1'b1}}) begin
          state_nxt = obl_pkg::ST_IDLE;
        end
      end
      obl_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = obl_pkg::ST_READ;
        end
      end
      obl_pkg::ST_READ: state_nxt = obl_pkg::ST_CMP;
      obl_pkg::ST_CMP: begin
        if (hit || last_probe) begin
          state_nxt = obl_pkg::ST_UPD;
        end else begin
          state_nxt = obl_pkg::ST_READ;
        end
      end
      obl_pkg::ST_UPD: state_nxt = is_rm ? obl_pkg::ST_WAIT : obl_pkg::ST_DONE;
      obl_pkg::ST_WAIT: begin
        if (!lv_stat.busy) begin
          state_nxt = obl_pkg::ST_DONE;
        end
      end
      obl_pkg::ST_DONE: state_nxt = obl_pkg::ST_IDLE;
      default: state_nxt = obl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = entry_r;
    lv_cmd        = '0;
    lv_cmd.price  = price_r;
    lv_cmd.amount = {16'd0, qty_r};
    lv_cmd.side   = side_r[0];
    unique case (state_r)
      obl_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      obl_pkg::ST_READ: ram_re = 1'b1;
      obl_pkg::ST_UPD: begin
        if (mode_r == obl_pkg::MODE_ADD) begin
          ram_we          = 1'b1;
          ram_wdata.valid = 1'b1;
          ram_wdata.side  = side_r[0];
          ram_wdata.qty   = qty_r;
          ram_wdata.delta = add_delta[23:0];
          ram_wdata.key   = key_r;
          lv_cmd.add_go   = 1'b1;
        end else if (is_rm) begin
          ram_we = 1'b1;
          if (entry_r.qty <= amount) begin
            ram_wdata.valid = 1'b0;
          end else begin
            ram_wdata.qty = entry_r.qty - amount;
          end
          lv_cmd.rm_go  = 1'b1;
          lv_cmd.side   = entry_r.side;
          lv_cmd.price  = actual;
          lv_cmd.amount = {16'd0, amount};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    probe_nxt     = probe_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    entry_nxt     = entry_r;
    mode_nxt      = mode_r;
    side_nxt      = side_r;
    sec_nxt       = sec_r;
    ts_nxt        = ts_r;
    price_nxt     = price_r;
    qty_nxt       = qty_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    o_time_nxt    = o_time_r;
    o_trade_nxt   = o_trade_r;
    o_bidp_nxt    = o_bidp_r;
    o_askp_nxt    = o_askp_r;
    o_bidq_nxt    = o_bidq_r;
    o_askq_nxt    = o_askq_r;
    o_sec_nxt     = o_sec_r;
    o_mode_nxt    = o_mode_r;
    o_side_nxt    = o_side_r;
    case (state_r)
      obl_pkg::ST_CLEAR: clr_addr_nxt = clr_addr_r + 1'b1;
      obl_pkg::ST_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          side_nxt  = in_side;
          sec_nxt   = in_instr_id;
          ts_nxt    = in_timestamp;
          price_nxt = in_price;
          qty_nxt   = in_quantity;
          key_nxt   = in_order_key;
          probe_nxt = '0;
          found_nxt = 1'b0;
        end
      end
      obl_pkg::ST_CMP: begin
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = ram_raddr;
          entry_nxt = ram_rdata;
        end else if (last_probe) begin
          found_nxt = 1'b0;
          slot_nxt  = key_r[obl_pkg::TBL_AW-1:0];
        end else begin
          probe_nxt = probe_r + 1'b1;
        end
      end
      obl_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        o_time_nxt    = ts_r;
        o_trade_nxt   = (mode_r == obl_pkg::MODE_TRADE) ? actual : 32'd0;
        o_bidp_nxt    = lv_stat.bid_px;
        o_askp_nxt    = lv_stat.ask_px;
        o_bidq_nxt    = lv_stat.bid_qty;
        o_askq_nxt    = lv_stat.ask_qty;
        o_sec_nxt     = sec_r;
        o_mode_nxt    = mode_r;
        o_side_nxt    = side_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= obl_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      probe_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      offset_r    <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      probe_r     <= probe_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && (paddr[2] == obl_pkg::REG_PX_BASE)) begin
        offset_r <= pwdata;
      end
    end
    slot_r    <= slot_nxt;
    entry_r   <= entry_nxt;
    mode_r    <= mode_nxt;
    side_r    <= side_nxt;
    sec_r     <= sec_nxt;
    ts_r      <= ts_nxt;
    price_r   <= price_nxt;
    qty_r     <= qty_nxt;
    key_r     <= key_nxt;
    o_time_r  <= o_time_nxt;
    o_trade_r <= o_trade_nxt;
    o_bidp_r  <= o_bidp_nxt;
    o_askp_r  <= o_askp_nxt;
    o_bidq_r  <= o_bidq_nxt;
    o_askq_r  <= o_askq_nxt;
    o_sec_r   <= o_sec_nxt;
    o_mode_r  <= o_mode_nxt;
    o_side_r  <= o_side_nxt;
  end

  assign busy             = (state_r != obl_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_time_out     = o_time_r;
  assign out_exec_px      = o_trade_r;
  assign out_best_bid_px  = o_bidp_r;
  assign out_best_ask_px  = o_askp_r;
  assign out_best_bid_qty = o_bidq_r;
  assign out_best_ask_qty = o_askq_r;
  assign out_security_out = o_sec_r;
  assign out_mode_out     = o_mode_r;
  assign out_side_out     = o_side_r;
  assign prdata = (paddr[2] == obl_pkg::REG_PX_BASE) ? offset_r : 32'd0;
  assign pready = 1'b1;

endmodule

### rtl/obl_checker.sv
// ----------------------------------------------------------------------------
// obl_checker
// Port-level checks of the order book level tracker, bound to the top level.
// ----------------------------------------------------------------------------
module obl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_exec_px,
  input logic [3:0]  out_mode_out,
  input logic        pready
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("An accepted transaction did not raise busy.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("The result strobe lasted more than one cycle.");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("A result appeared without a transaction in progress.");

  a_trade_price_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_mode_out != obl_pkg::MODE_TRADE)) |-> (out_exec_px == 32'd0))
    else $error("Trade price is nonzero for a non-trade transaction.");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("The configuration port stalled.");

endmodule

bind order_book_level_tracker obl_checker u_obl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_exec_px (out_exec_px),
  .out_mode_out(out_mode_out),
  .pready      (pready)
);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book level tracker testbench
// Drives decoded market messages through the command port and predicts every
// snapshot with a behavioral copy of the order table and both level tables.
// Directed tests cover pass-through modes, probe chains, slot wrap, full
// level tables and offset extremes; random phases mix adds, cancels, trades
// and noise under several price offsets.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [3:0]  mode;
    logic [3:0]  side;
    logic [7:0]  instr_id;
    logic [31:0] timestamp;
    logic [31:0] price;
    logic [15:0] quantity;
    logic [31:0] order_key;
  } market_msg_t;

  typedef struct {
    logic [31:0] time_out;
    logic [31:0] exec_px;
    logic [31:0] bid_px;
    logic [31:0] ask_px;
    logic [31:0] bid_qty;
    logic [31:0] ask_qty;
    logic [7:0]  security;
    logic [3:0]  mode;
    logic [3:0]  side;
  } snapshot_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_mode;
  logic [3:0]  in_side;
  logic [7:0]  in_instr_id;
  logic [31:0] in_timestamp;
  logic [31:0] in_price;
  logic [15:0] in_quantity;
  logic [31:0] in_order_key;
  logic        out_valid;
  logic [31:0] out_time_out;
  logic [31:0] out_exec_px;
  logic [31:0] out_best_bid_px;
  logic [31:0] out_best_ask_px;
  logic [31:0] out_best_bid_qty;
  logic [31:0] out_best_ask_qty;
  logic [7:0]  out_security_out;
  logic [3:0]  out_mode_out;
  logic [3:0]  out_side_out;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted book state.
  logic [31:0] book_offset;
  logic [31:0] ord_key [obl_pkg::TABLE_DEPTH];
  logic [23:0] ord_delta [obl_pkg::TABLE_DEPTH];
  logic [15:0] ord_qty [obl_pkg::TABLE_DEPTH];
  logic        ord_side [obl_pkg::TABLE_DEPTH];
  logic        ord_valid [obl_pkg::TABLE_DEPTH];
  logic [31:0] lvl_price [2][obl_pkg::LEVEL_COUNT];
  logic [31:0] lvl_qty [2][obl_pkg::LEVEL_COUNT];

  snapshot_t   pending_snapshots[$];
  logic [31:0] known_ids[$];
  int          errors = 0;
  int          checked = 0;
  int          cycles = 0;
  int          sent_adds = 0;
  int          sent_removes = 0;
  int          sent_other = 0;

  order_book_level_tracker i_dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("order_book_level_tracker: mismatch");
      $finish;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    snapshot_t s;
    if (rst_n && out_valid) begin
      if (pending_snapshots.size() == 0) begin
        $error("snapshot with no transaction outstanding");
        errors++;
      end else begin
        s = pending_snapshots.pop_front();
        checked++;
        check_field("time_out", s.time_out, out_time_out);
        check_field("exec_px", s.exec_px, out_exec_px);
        check_field("best_bid_px", s.bid_px, out_best_bid_px);
        check_field("best_ask_px", s.ask_px, out_best_ask_px);
        check_field("best_bid_qty", s.bid_qty, out_best_bid_qty);
        check_field("best_ask_qty", s.ask_qty, out_best_ask_qty);
        check_field("security_out", 32'(s.security), 32'(out_security_out));
        check_field("mode_out", 32'(s.mode), 32'(out_mode_out));
        check_field("side_out", 32'(s.side), 32'(out_side_out));
      end
    end
  end

  function automatic snapshot_t apply_message(market_msg_t m);
    snapshot_t   s;
    int          base;
    int          slot;
    int          idx;
    int          lvl;
    bit          found;
    logic [31:0] resolved;
    logic [31:0] amount;
    int          sd;
    base  = int'(m.order_key % obl_pkg::TABLE_DEPTH);
    slot  = base;
    found = 0;
    for (int p = 0; p < obl_pkg::PROBE_COUNT; p++) begin
      idx = (base + p) % obl_pkg::TABLE_DEPTH;
      if (!found && ord_valid[idx] && ord_key[idx] == m.order_key) begin
        found = 1;
        slot  = idx;
      end
    end
    resolved = found ? book_offset + 32'(ord_delta[slot]) : m.price;
    amount   = (m.mode == obl_pkg::MODE_CANCEL && found) ? 32'(ord_qty[slot])
                                                         : 32'(m.quantity);
    if (m.mode == obl_pkg::MODE_ADD) begin
      sd = m.side[0];
      ord_valid[slot] = 1'b1;
      ord_key[slot]   = m.order_key;
      ord_delta[slot] = 24'(m.price - book_offset);
      ord_qty[slot]   = m.quantity;
      ord_side[slot]  = m.side[0];
      lvl = obl_pkg::LEVEL_COUNT;
      for (int j = 0; j < obl_pkg::LEVEL_COUNT; j++) begin
        if (lvl_price[sd][j] == m.price) begin
          lvl = j;
          break;
        end
        if (lvl == obl_pkg::LEVEL_COUNT && lvl_qty[sd][j] == 0) lvl = j;
      end
      if (lvl < obl_pkg::LEVEL_COUNT) begin
        lvl_qty[sd][lvl]   = lvl_qty[sd][lvl] + 32'(m.quantity);
        lvl_price[sd][lvl] = m.price;
      end
    end else if ((m.mode == obl_pkg::MODE_CANCEL || m.mode == obl_pkg::MODE_TRADE)
                 && found) begin
      sd = ord_side[slot];
      if (32'(ord_qty[slot]) <= amount) ord_valid[slot] = 1'b0;
      else ord_qty[slot] = ord_qty[slot] - amount[15:0];
      for (int j = 0; j < obl_pkg::LEVEL_COUNT; j++) begin
        if (lvl_price[sd][j] == resolved) begin
          lvl_qty[sd][j] = (lvl_qty[sd][j] > amount) ? lvl_qty[sd][j] - amount : 32'd0;
          if (lvl_qty[sd][j] == 0) begin
            for (int k = j; k < obl_pkg::LEVEL_COUNT - 1; k++) begin
              lvl_price[sd][k] = lvl_price[sd][k + 1];
              lvl_qty[sd][k]   = lvl_qty[sd][k + 1];
            end
            lvl_price[sd][obl_pkg::LEVEL_COUNT - 1] = 0;
            lvl_qty[sd][obl_pkg::LEVEL_COUNT - 1]   = 0;
          end
        end
      end
    end
    s.time_out = m.timestamp;
    s.exec_px  = (m.mode == obl_pkg::MODE_TRADE) ? resolved : 32'd0;
    s.bid_px   = lvl_price[0][0];
    s.ask_px   = lvl_price[1][0];
    s.bid_qty  = lvl_qty[0][0];
    s.ask_qty  = lvl_qty[1][0];
    s.security = m.instr_id;
    s.mode     = m.mode;
    s.side     = m.side;
    return s;
  endfunction

  task automatic send_message(market_msg_t m);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_mode      <= m.mode;
    in_side      <= m.side;
    in_instr_id  <= m.instr_id;
    in_timestamp <= m.timestamp;
    in_price     <= m.price;
    in_quantity  <= m.quantity;
    in_order_key <= m.order_key;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_snapshots.push_back(apply_message(m));
    if (m.mode == obl_pkg::MODE_ADD) begin
      sent_adds++;
      known_ids.push_back(m.order_key);
      if (known_ids.size() > 48) void'(known_ids.pop_front());
    end else if (m.mode == obl_pkg::MODE_CANCEL || m.mode == obl_pkg::MODE_TRADE) begin
      sent_removes++;
    end else begin
      sent_other++;
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_offset(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(obl_pkg::REG_PX_BASE) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    book_offset = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("offset readback", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic market_msg_t make_msg(logic [3:0] mode, logic [3:0] side,
                                           logic [31:0] price, logic [15:0] qty,
                                           logic [31:0] id);
    market_msg_t m;
    m.mode      = mode;
    m.side      = side;
    m.instr_id  = 8'($urandom);
    m.timestamp = $urandom;
    m.price     = price;
    m.quantity  = qty;
    m.order_key = id;
    return m;
  endfunction

  task automatic test_pass_through_and_levels;
    send_message(make_msg(4'd0, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_message(make_msg(4'd15, 4'd15, 32'd0, 16'd0, 32'd0));
    send_message(make_msg(obl_pkg::MODE_ADD, 4'd0, 32'd100, 16'd10, 32'h0000_0005));
    send_message(make_msg(obl_pkg::MODE_ADD, 4'd1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_message(make_msg(obl_pkg::MODE_ADD, 4'd14, 32'd100, 16'd7, 32'h0000_0405));
    send_message(make_msg(obl_pkg::MODE_TRADE, 4'd0, 32'd1, 16'd3, 32'h0000_0005));
    send_message(make_msg(obl_pkg::MODE_CANCEL, 4'd0, 32'd1, 16'd0, 32'h0000_0405));
    send_message(make_msg(obl_pkg::MODE_CANCEL, 4'd0, 32'd1, 16'd0, 32'h1234_5678));
    send_message(make_msg(obl_pkg::MODE_TRADE, 4'd1, 32'd77, 16'd1, 32'h0BAD_0BAD));
    send_message(make_msg(obl_pkg::MODE_TRADE, 4'd1, 32'd0, 16'hFFFF, 32'hFFFF_FFFF));
    send_message(make_msg(obl_pkg::MODE_CANCEL, 4'd0, 32'd0, 16'd0, 32'h0000_0005));
    drain();
  endtask

  // Five orders share the last base slot, so the probe reads wrap to slot 0 and
  // each new add overwrites the base slot. The bid side also overflows its levels.
  task automatic test_probe_chain_and_full_levels;
    for (int i = 0; i < 5; i++)
      send_message(make_msg(obl_pkg::MODE_ADD, 4'd2, 32'd200 + i, 16'd5,
                            (i << 10) | 32'd1023));
    for (int i = 0; i < 7; i++)
      send_message(make_msg(obl_pkg::MODE_ADD, 4'd0, 32'd300 + i, 16'd1,
                            32'h0100_0000 + i));
    send_message(make_msg(obl_pkg::MODE_TRADE, 4'd0, 32'd0, 16'd2, (3 << 10) | 32'd1023));
    send_message(make_msg(obl_pkg::MODE_CANCEL, 4'd0, 32'd0, 16'd0, (4 << 10) | 32'd1023));
    send_message(make_msg(obl_pkg::MODE_CANCEL, 4'd0, 32'd0, 16'd0, 32'd1023));
    drain();
  endtask

  task automatic test_offset_extremes;
    write_offset(32'hFFFF_FFFF);
    send_message(make_msg(obl_pkg::MODE_ADD, 4'd1, 32'd5, 16'd9, 32'h00AB_0010));
    send_message(make_msg(obl_pkg::MODE_TRADE, 4'd1, 32'd0, 16'd4, 32'h00AB_0010));
    send_message(make_msg(obl_pkg::MODE_ADD, 4'd0, 32'hFF00_0000, 16'd3, 32'h00AB_0011));
    send_message(make_msg(obl_pkg::MODE_TRADE, 4'd0, 32'd0, 16'd9, 32'h00AB_0011));
    drain();
    write_offset(32'd0);
  endtask

  function automatic logic [31:0] pick_id();
    logic [31:0] id;
    if (known_ids.size() != 0 && $urandom_range(0, 3) != 0)
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
    id = $urandom;
    case ($urandom_range(0, 3))
      0: id[9:0] = 10'($urandom_range(1020, 1023));
      1: id[9:0] = 10'($urandom_range(0, 3));
      2: id[31:10] = 22'($urandom_range(0, 3));
      default: ;
    endcase
    return id;
  endfunction

  task automatic test_random_phase(int count, logic [31:0] offset);
    market_msg_t m;
    int          r;
    write_offset(offset);
    for (int n = 0; n < count; n++) begin
      m = make_msg(obl_pkg::MODE_ADD, 4'($urandom), offset + $urandom_range(0, 12),
                   16'($urandom_range(1, 40)), pick_id());
      r = $urandom_range(0, 99);
      if (r < 8) m.price = $urandom;
      if (r % 17 == 0) m.quantity = (r & 1) ? 16'hFFFF : 16'd0;
      if (r % 13 == 0) m.quantity = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 50) m.mode = obl_pkg::MODE_ADD;
      else if (r < 70) m.mode = obl_pkg::MODE_CANCEL;
      else if (r < 88) m.mode = obl_pkg::MODE_TRADE;
      else m.mode = 4'($urandom);
      send_message(m);
    end
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_mode      = '0;
    in_side      = '0;
    in_instr_id  = '0;
    in_timestamp = '0;
    in_price     = '0;
    in_quantity  = '0;
    in_order_key = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    book_offset  = '0;
    for (int i = 0; i < obl_pkg::TABLE_DEPTH; i++) ord_valid[i] = 1'b0;
    for (int j = 0; j < obl_pkg::LEVEL_COUNT; j++) begin
      lvl_price[0][j] = 0;
      lvl_price[1][j] = 0;
      lvl_qty[0][j]   = 0;
      lvl_qty[1][j]   = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    write_offset(32'd0);
    test_pass_through_and_levels();
    test_probe_chain_and_full_levels();
    test_offset_extremes();
    test_random_phase(350, 32'd0);
    test_random_phase(330, 32'hFFFF_FFF8);
    test_random_phase(330, $urandom);
    test_random_phase(330, 32'h8000_0000);

    $display("Covered %0d adds, %0d cancels or trades, %0d other messages.",
             sent_adds, sent_removes, sent_other);
    $display("Checked %0d snapshots under five price offsets.", checked);
    if (errors == 0 && pending_snapshots.size() == 0) begin
      $display("order_book_level_tracker: match");
    end else begin
      $display("order_book_level_tracker: mismatch");
    end
    $finish;
  end

endmodule
